>>> design/tccf_pkg.sv
// ----------------------------------------------------------------------------
// tccf_pkg
// Shared codes, stage types and small arithmetic helpers for the track
// cylinder crossing filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tccf_pkg;

  localparam logic [2:0] KIND_OPTICAL  = 3'd0;
  localparam logic [2:0] KIND_ELECTRON = 3'd1;
  localparam logic [2:0] KIND_GAMMA    = 3'd2;
  localparam logic [2:0] KIND_MASSLESS = 3'd3;
  localparam logic [2:0] KIND_MUON     = 3'd4;

  localparam logic [19:0] ENERGY_CUT_KEV = 20'd240;

  localparam logic [2:0] CFG_AXIS_X    = 3'd0;
  localparam logic [2:0] CFG_AXIS_Y    = 3'd1;
  localparam logic [2:0] CFG_RADIUS    = 3'd2;
  localparam logic [2:0] CFG_FLOOR_Z   = 3'd3;
  localparam logic [2:0] CFG_CEILING_Z = 3'd4;

  localparam int D_W      = 84;
  localparam int ROOT_W   = D_W / 2;
  localparam int REM_W    = ROOT_W + 4;
  localparam int SQ_STEPS = ROOT_W;

  typedef struct packed {
    logic [41:0] hh;
    logic [40:0] hl;
    logic [39:0] ll;
  } sqp_t;

  typedef struct packed {
    logic        dead;
    logic [2:0]  kind;
    logic        elow;
    logic [24:0] dx;
    logic [24:0] dy;
    logic [24:0] nt;
    logic [24:0] nb;
    logic [15:0] ux;
    logic [15:0] uy;
    logic [15:0] uz;
  } s1_t;

  typedef struct packed {
    logic        dead;
    logic [2:0]  kind;
    logic        elow;
    logic [24:0] nt;
    logic [24:0] nb;
    logic [15:0] uz;
    logic [47:0] dxdx;
    logic [47:0] dydy;
    logic [45:0] r2;
    logic [31:0] uxux;
    logic [31:0] uyuy;
    logic [40:0] dxux;
    logic [40:0] dyuy;
    logic [40:0] dxuz;
    logic [40:0] dyuz;
    logic [40:0] ntux;
    logic [40:0] ntuy;
    logic [40:0] nbux;
    logic [40:0] nbuy;
    logic [38:0] ru;
  } s2_t;

  typedef struct packed {
    logic        dead;
    logic [2:0]  kind;
    logic        elow;
    logic [24:0] nt;
    logic [24:0] nb;
    logic [15:0] uz;
    logic [50:0] c;
    logic [31:0] a;
    logic [41:0] b;
    logic [41:0] pxt;
    logic [41:0] pyt;
    logic [41:0] pxb;
    logic [41:0] pyb;
    logic [38:0] ru;
  } s3_t;

  typedef struct packed {
    logic        pre_done;
    logic        pre_keep;
    logic        dt_ok;
    logic        db_ok;
    logic        a_nz;
    logic        c_neg;
    logic [15:0] uz;
    logic [41:0] b;
    logic [57:0] lim_lo;
    logic [57:0] lim_hi;
    sqp_t        p_pxt;
    sqp_t        p_pyt;
    sqp_t        p_pxb;
    sqp_t        p_pyb;
    sqp_t        p_b;
    sqp_t        p_ru;
    logic [56:0] ach;
    logic [56:0] acl;
  } s4_t;

  typedef struct packed {
    logic        pre_done;
    logic        pre_keep;
    logic        dt_ok;
    logic        db_ok;
    logic        a_nz;
    logic        c_neg;
    logic [15:0] uz;
    logic [41:0] b;
    logic [57:0] lim_lo;
    logic [57:0] lim_hi;
    logic [81:0] q_pxt;
    logic [81:0] q_pyt;
    logic [81:0] q_pxb;
    logic [81:0] q_pyb;
    logic [81:0] q_b;
    logic [81:0] q_ru;
    logic [81:0] ac;
  } s5_t;

  typedef struct packed {
    logic        pre_done;
    logic        pre_keep;
    logic        disc_hit;
    logic        wall_ok;
    logic [15:0] uz;
    logic [41:0] b;
    logic [57:0] lim_lo;
    logic [57:0] lim_hi;
  } side_t;

  typedef struct packed {
    side_t             side;
    logic [D_W-1:0]    d;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] q;
  } sq_t;

  typedef struct packed {
    side_t       side;
    logic [43:0] u0;
    logic [43:0] u1;
  } p1_t;

  typedef struct packed {
    logic        pre_done;
    logic        pre_keep;
    logic        disc_hit;
    logic        wall_ok;
    logic        u0p;
    logic        u1p;
    logic [57:0] lim_lo;
    logic [57:0] lim_hi;
    logic [59:0] t0;
    logic [59:0] t1;
  } p2_t;

  function automatic logic [40:0] mag41(input logic [41:0] v);
    logic [41:0] t;
    t = v[41] ? 42'(~v + 42'd1) : v;
    return t[40:0];
  endfunction

  function automatic sqp_t sq_split(input logic [40:0] m);
    sqp_t p;
    p.hh = m[40:20] * m[40:20];
    p.hl = m[40:20] * m[19:0];
    p.ll = m[19:0] * m[19:0];
    return p;
  endfunction

  function automatic logic [81:0] sq_join(input sqp_t p);
    return {p.hh, 40'b0} + {20'b0, p.hl, 21'b0} + {42'b0, p.ll};
  endfunction

  function automatic sq_t sq_step(input sq_t s);
    sq_t              o;
    logic [REM_W-1:0] sh;
    logic [REM_W-1:0] trial;
    o = s;
    sh = {s.rem[REM_W-3:0], s.d[D_W-1 -: 2]};
    trial = {2'b0, s.q, 2'b01};
    o.d = {s.d[D_W-3:0], 2'b0};
    if (sh >= trial) begin
      o.rem = sh - trial;
      o.q = {s.q[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem = sh;
      o.q = {s.q[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

>>> design/track_cylinder_crossing_filter_core.sv
// ----------------------------------------------------------------------------
// track_cylinder_crossing_filter_core
// Keep or kill decision per track against a vertical detector cylinder,
// with exact disc and side wall crossing tests in a deep pipeline.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------
//  in      | in_valid / in_ready   | already_dead, kind, energy, pos, dir
//  out     | out_valid / out_ready | keep
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One track per cycle while the out channel is not stalled; six arithmetic
//  stages, one stage per root bit of the 42 step square root, then three closing stages.
//  Reset clears the valid bits and the cylinder registers.
//  A stalled out channel holds the whole pipeline; in_ready follows it.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module track_cylinder_crossing_filter_core
  import tccf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_already_dead,
  input  logic [2:0]  in_particle_kind,
  input  logic [19:0] in_energy_kev,
  input  logic [23:0] in_pos_x,
  input  logic [23:0] in_pos_y,
  input  logic [23:0] in_pos_z,
  input  logic [15:0] in_dir_x,
  input  logic [15:0] in_dir_y,
  input  logic [15:0] in_dir_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_keep,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  logic [23:0] axis_x_r, axis_y_r, floor_z_r, ceiling_z_r;
  logic [22:0] radius_r;
  logic        adv;

  s1_t s1_r, s1_nxt;
  s2_t s2_r, s2_nxt;
  s3_t s3_r, s3_nxt;
  s4_t s4_r, s4_nxt;
  s5_t s5_r, s5_nxt;
  sq_t s6_r, s6_nxt;
  sq_t sq_r   [SQ_STEPS];
  sq_t sq_nxt [SQ_STEPS];
  p1_t p1_r, p1_nxt;
  p2_t p2_r, p2_nxt;
  logic keep_r, keep_nxt;

  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r, s6_vld_r;
  logic [SQ_STEPS-1:0] sq_vld_r;
  logic p1_vld_r, p2_vld_r, out_valid_r;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_keep  = keep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_x_r    <= '0;
      axis_y_r    <= '0;
      radius_r    <= '0;
      floor_z_r   <= '0;
      ceiling_z_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_AXIS_X:    axis_x_r    <= cfg_data;
        CFG_AXIS_Y:    axis_y_r    <= cfg_data;
        CFG_RADIUS:    radius_r    <= cfg_data[22:0];
        CFG_FLOOR_Z:   floor_z_r   <= cfg_data;
        CFG_CEILING_Z: ceiling_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // offsets from the axis and to the planes
  always_comb begin
    s1_nxt.dead = in_already_dead;
    s1_nxt.kind = in_particle_kind;
    s1_nxt.elow = in_energy_kev < ENERGY_CUT_KEV;
    s1_nxt.dx = {in_pos_x[23], in_pos_x} - {axis_x_r[23], axis_x_r};
    s1_nxt.dy = {in_pos_y[23], in_pos_y} - {axis_y_r[23], axis_y_r};
    s1_nxt.nt = {ceiling_z_r[23], ceiling_z_r} - {in_pos_z[23], in_pos_z};
    s1_nxt.nb = {floor_z_r[23], floor_z_r} - {in_pos_z[23], in_pos_z};
    s1_nxt.ux = in_dir_x;
    s1_nxt.uy = in_dir_y;
    s1_nxt.uz = in_dir_z;
  end

  // products
  always_comb begin
    logic signed [49:0] pdx, pdy;
    logic signed [31:0] pux, puy;
    logic [15:0]        uzm;
    pdx = $signed(s1_r.dx) * $signed(s1_r.dx);
    pdy = $signed(s1_r.dy) * $signed(s1_r.dy);
    pux = $signed(s1_r.ux) * $signed(s1_r.ux);
    puy = $signed(s1_r.uy) * $signed(s1_r.uy);
    uzm = s1_r.uz[15] ? 16'(~s1_r.uz + 16'd1) : s1_r.uz;
    s2_nxt.dead = s1_r.dead;
    s2_nxt.kind = s1_r.kind;
    s2_nxt.elow = s1_r.elow;
    s2_nxt.nt = s1_r.nt;
    s2_nxt.nb = s1_r.nb;
    s2_nxt.uz = s1_r.uz;
    s2_nxt.dxdx = pdx[47:0];
    s2_nxt.dydy = pdy[47:0];
    s2_nxt.r2 = radius_r * radius_r;
    s2_nxt.uxux = pux;
    s2_nxt.uyuy = puy;
    s2_nxt.dxux = $signed(s1_r.dx) * $signed(s1_r.ux);
    s2_nxt.dyuy = $signed(s1_r.dy) * $signed(s1_r.uy);
    s2_nxt.dxuz = $signed(s1_r.dx) * $signed(s1_r.uz);
    s2_nxt.dyuz = $signed(s1_r.dy) * $signed(s1_r.uz);
    s2_nxt.ntux = $signed(s1_r.nt) * $signed(s1_r.ux);
    s2_nxt.ntuy = $signed(s1_r.nt) * $signed(s1_r.uy);
    s2_nxt.nbux = $signed(s1_r.nb) * $signed(s1_r.ux);
    s2_nxt.nbuy = $signed(s1_r.nb) * $signed(s1_r.uy);
    s2_nxt.ru = radius_r * uzm;
  end

  // sums
  always_comb begin
    s3_nxt.dead = s2_r.dead;
    s3_nxt.kind = s2_r.kind;
    s3_nxt.elow = s2_r.elow;
    s3_nxt.nt = s2_r.nt;
    s3_nxt.nb = s2_r.nb;
    s3_nxt.uz = s2_r.uz;
    s3_nxt.ru = s2_r.ru;
    s3_nxt.c = {3'b0, s2_r.dxdx} + {3'b0, s2_r.dydy} - {5'b0, s2_r.r2};
    s3_nxt.a = s2_r.uxux + s2_r.uyuy;
    s3_nxt.b = {s2_r.dxux[40], s2_r.dxux} + {s2_r.dyuy[40], s2_r.dyuy};
    s3_nxt.pxt = {s2_r.dxuz[40], s2_r.dxuz} + {s2_r.ntux[40], s2_r.ntux};
    s3_nxt.pyt = {s2_r.dyuz[40], s2_r.dyuz} + {s2_r.ntuy[40], s2_r.ntuy};
    s3_nxt.pxb = {s2_r.dxuz[40], s2_r.dxuz} + {s2_r.nbux[40], s2_r.nbux};
    s3_nxt.pyb = {s2_r.dyuz[40], s2_r.dyuz} + {s2_r.nbuy[40], s2_r.nbuy};
  end

  // early decision, partial squares
  always_comb begin
    logic        rho_gt, rho_lt, b_pos, uz_pos, uz_neg;
    logic        nt_pos, nt_neg, nb_pos, nb_neg, kill_mu, keep_in;
    logic [50:0] cm;
    rho_gt = !s3_r.c[50] && (s3_r.c != '0);
    rho_lt = s3_r.c[50];
    b_pos  = !s3_r.b[41] && (s3_r.b != '0);
    uz_neg = s3_r.uz[15];
    uz_pos = !s3_r.uz[15] && (s3_r.uz != '0);
    nt_neg = s3_r.nt[24];
    nt_pos = !s3_r.nt[24] && (s3_r.nt != '0);
    nb_neg = s3_r.nb[24];
    nb_pos = !s3_r.nb[24] && (s3_r.nb != '0);
    kill_mu = (nb_pos && uz_neg) || (nt_neg && uz_pos) || (rho_gt && b_pos);
    keep_in = rho_lt && nb_neg && nt_pos;
    s4_nxt.pre_done = 1'b1;
    s4_nxt.pre_keep = 1'b0;
    if (s3_r.dead) begin
      s4_nxt.pre_keep = 1'b0;
    end else if (s3_r.kind == KIND_OPTICAL) begin
      s4_nxt.pre_keep = 1'b1;
    end else if ((s3_r.kind inside {KIND_ELECTRON, KIND_GAMMA}) && s3_r.elow) begin
      s4_nxt.pre_keep = 1'b0;
    end else if (s3_r.kind == KIND_MASSLESS) begin
      s4_nxt.pre_keep = 1'b0;
    end else if (s3_r.kind != KIND_MUON) begin
      s4_nxt.pre_keep = !nb_pos && !rho_gt && !nt_neg;
    end else if (kill_mu) begin
      s4_nxt.pre_keep = 1'b0;
    end else if (keep_in) begin
      s4_nxt.pre_keep = 1'b1;
    end else begin
      s4_nxt.pre_done = 1'b0;
    end
    s4_nxt.dt_ok = (s3_r.uz != '0) && (s3_r.nt != '0) && (s3_r.nt[24] == s3_r.uz[15]);
    s4_nxt.db_ok = (s3_r.uz != '0) && (s3_r.nb != '0) && (s3_r.nb[24] == s3_r.uz[15]);
    s4_nxt.a_nz = s3_r.a != '0;
    s4_nxt.c_neg = s3_r.c[50];
    s4_nxt.uz = s3_r.uz;
    s4_nxt.b = s3_r.b;
    s4_nxt.lim_lo = $signed(s3_r.nb) * $signed({1'b0, s3_r.a});
    s4_nxt.lim_hi = $signed(s3_r.nt) * $signed({1'b0, s3_r.a});
    s4_nxt.p_pxt = sq_split(mag41(s3_r.pxt));
    s4_nxt.p_pyt = sq_split(mag41(s3_r.pyt));
    s4_nxt.p_pxb = sq_split(mag41(s3_r.pxb));
    s4_nxt.p_pyb = sq_split(mag41(s3_r.pyb));
    s4_nxt.p_b = sq_split(mag41(s3_r.b));
    s4_nxt.p_ru = sq_split({2'b0, s3_r.ru});
    cm = s3_r.c[50] ? 51'(~s3_r.c + 51'd1) : s3_r.c;
    s4_nxt.ach = s3_r.a * cm[49:25];
    s4_nxt.acl = s3_r.a * cm[24:0];
  end

  // join partial products
  always_comb begin
    s5_nxt.pre_done = s4_r.pre_done;
    s5_nxt.pre_keep = s4_r.pre_keep;
    s5_nxt.dt_ok = s4_r.dt_ok;
    s5_nxt.db_ok = s4_r.db_ok;
    s5_nxt.a_nz = s4_r.a_nz;
    s5_nxt.c_neg = s4_r.c_neg;
    s5_nxt.uz = s4_r.uz;
    s5_nxt.b = s4_r.b;
    s5_nxt.lim_lo = s4_r.lim_lo;
    s5_nxt.lim_hi = s4_r.lim_hi;
    s5_nxt.q_pxt = sq_join(s4_r.p_pxt);
    s5_nxt.q_pyt = sq_join(s4_r.p_pyt);
    s5_nxt.q_pxb = sq_join(s4_r.p_pxb);
    s5_nxt.q_pyb = sq_join(s4_r.p_pyb);
    s5_nxt.q_b = sq_join(s4_r.p_b);
    s5_nxt.q_ru = sq_join(s4_r.p_ru);
    s5_nxt.ac = {s4_r.ach, 25'b0} + {25'b0, s4_r.acl};
  end

  // disc tests and discriminant
  always_comb begin
    logic [82:0]    lhs_t, lhs_b;
    logic [D_W-1:0] d;
    lhs_t = {1'b0, s5_r.q_pxt} + {1'b0, s5_r.q_pyt};
    lhs_b = {1'b0, s5_r.q_pxb} + {1'b0, s5_r.q_pyb};
    if (s5_r.c_neg) begin
      d = {2'b0, s5_r.q_b} + {2'b0, s5_r.ac};
    end else begin
      d = {2'b0, s5_r.q_b} - {2'b0, s5_r.ac};
    end
    s6_nxt.side.pre_done = s5_r.pre_done;
    s6_nxt.side.pre_keep = s5_r.pre_keep;
    s6_nxt.side.disc_hit = (s5_r.dt_ok && (lhs_t < {1'b0, s5_r.q_ru}))
                        || (s5_r.db_ok && (lhs_b < {1'b0, s5_r.q_ru}));
    s6_nxt.side.wall_ok = s5_r.a_nz && !d[D_W-1] && (d != '0);
    s6_nxt.side.uz = s5_r.uz;
    s6_nxt.side.b = s5_r.b;
    s6_nxt.side.lim_lo = s5_r.lim_lo;
    s6_nxt.side.lim_hi = s5_r.lim_hi;
    s6_nxt.d = d;
    s6_nxt.rem = '0;
    s6_nxt.q = '0;
  end

  // one root bit per stage
  always_comb begin
    sq_nxt[0] = sq_step(s6_r);
    for (int k = 1; k < SQ_STEPS; k++) begin
      sq_nxt[k] = sq_step(sq_r[k-1]);
    end
  end

  // wall crossing parameters
  always_comb begin
    logic [43:0] bx, sx;
    bx = {{2{sq_r[SQ_STEPS-1].side.b[41]}}, sq_r[SQ_STEPS-1].side.b};
    sx = {2'b0, sq_r[SQ_STEPS-1].q};
    p1_nxt.side = sq_r[SQ_STEPS-1].side;
    p1_nxt.u0 = 44'd0 - bx - sx;
    p1_nxt.u1 = sx - bx;
  end

  always_comb begin
    p2_nxt.pre_done = p1_r.side.pre_done;
    p2_nxt.pre_keep = p1_r.side.pre_keep;
    p2_nxt.disc_hit = p1_r.side.disc_hit;
    p2_nxt.wall_ok = p1_r.side.wall_ok;
    p2_nxt.lim_lo = p1_r.side.lim_lo;
    p2_nxt.lim_hi = p1_r.side.lim_hi;
    p2_nxt.u0p = !p1_r.u0[43] && (p1_r.u0 != '0);
    p2_nxt.u1p = !p1_r.u1[43] && (p1_r.u1 != '0);
    p2_nxt.t0 = $signed(p1_r.side.uz) * $signed(p1_r.u0);
    p2_nxt.t1 = $signed(p1_r.side.uz) * $signed(p1_r.u1);
  end

  always_comb begin
    logic h0, h1;
    h0 = p2_r.u0p && ($signed(p2_r.lim_lo) < $signed(p2_r.t0))
      && ($signed(p2_r.t0) < $signed(p2_r.lim_hi));
    h1 = p2_r.u1p && ($signed(p2_r.lim_lo) < $signed(p2_r.t1))
      && ($signed(p2_r.t1) < $signed(p2_r.lim_hi));
    keep_nxt = p2_r.pre_done ? p2_r.pre_keep
             : (p2_r.disc_hit || (p2_r.wall_ok && (h0 || h1)));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
      s4_r <= s4_nxt;
      s5_r <= s5_nxt;
      s6_r <= s6_nxt;
      for (int k = 0; k < SQ_STEPS; k++) begin
        sq_r[k] <= sq_nxt[k];
      end
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
      keep_r <= keep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
      sq_vld_r <= '0;
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= s5_vld_r;
      sq_vld_r <= {sq_vld_r[SQ_STEPS-2:0], s6_vld_r};
      p1_vld_r <= sq_vld_r[SQ_STEPS-1];
      p2_vld_r <= p1_vld_r;
      out_valid_r <= p2_vld_r;
    end
  end

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid && !p2_vld_r)
    else $error("valid bits survive reset");

  a_root_rem: assert property (@(posedge clk) disable iff (!rst_n)
    sq_vld_r[SQ_STEPS-1] |->
      sq_r[SQ_STEPS-1].rem <= {3'b0, sq_r[SQ_STEPS-1].q, 1'b0})
    else $error("square root remainder out of bound");

  a_pre_kill: assert property (@(posedge clk) disable iff (!rst_n)
    adv && p2_vld_r && p2_r.pre_done && !p2_r.pre_keep |=> out_valid && !out_keep)
    else $error("early kill decision lost");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv && sq_vld_r[0] |=> sq_vld_r[0] && $stable(sq_r[0].q))
    else $error("root stage moved under stall");

endmodule

>>> tb/tccf_checker.sv
// ----------------------------------------------------------------------------
// tccf_checker
// Watches the cfg, in and out channels of the track cylinder crossing filter.
// It predicts the keep/kill decision of every accepted track with exact wide
// integer arithmetic and compares it, in order, with the decisions returned.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tccf_checker
  import tccf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_already_dead,
  input  logic [2:0]  in_particle_kind,
  input  logic [19:0] in_energy_kev,
  input  logic [23:0] in_pos_x,
  input  logic [23:0] in_pos_y,
  input  logic [23:0] in_pos_z,
  input  logic [15:0] in_dir_x,
  input  logic [15:0] in_dir_y,
  input  logic [15:0] in_dir_z,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_keep,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output int          fail_count,
  output int          decisions_pending
);

  typedef logic signed [127:0] wide_t;

  logic signed [23:0] cyl_x, cyl_y, cyl_floor, cyl_ceiling;
  logic [22:0]        cyl_radius;
  bit                 keep_queue[$];

  function automatic wide_t isqrt(wide_t d);
    wide_t r, c;
    r = 0;
    for (int i = 43; i >= 0; i--) begin
      c = r | (wide_t'(1) << i);
      if (c * c <= d) r = c;
    end
    return r;
  endfunction

  function automatic bit predict_keep(logic dead, logic [2:0] kind, logic [19:0] energy,
                                      logic signed [23:0] x, logic signed [23:0] y,
                                      logic signed [23:0] z, logic signed [15:0] ux,
                                      logic signed [15:0] uy, logic signed [15:0] uz);
    wide_t dx, dy, wz, wux, wuy, wuz, fl, ce, rho2, r2;
    wide_t n, px, py, a, b, c, d, s, u, t;
    dx = wide_t'(x) - wide_t'(cyl_x);
    dy = wide_t'(y) - wide_t'(cyl_y);
    wz = wide_t'(z);
    wux = wide_t'(ux);
    wuy = wide_t'(uy);
    wuz = wide_t'(uz);
    fl = wide_t'(cyl_floor);
    ce = wide_t'(cyl_ceiling);
    rho2 = dx * dx + dy * dy;
    r2 = wide_t'({1'b0, cyl_radius}) * wide_t'({1'b0, cyl_radius});
    if (dead) return 1'b0;
    if (kind == KIND_OPTICAL) return 1'b1;
    if ((kind == KIND_ELECTRON || kind == KIND_GAMMA) && energy < ENERGY_CUT_KEV)
      return 1'b0;
    if (kind == KIND_MASSLESS) return 1'b0;
    if (kind != KIND_MUON) return !(wz < fl || rho2 > r2 || wz > ce);
    if (wz < fl && wuz < 0) return 1'b0;
    if (wz > ce && wuz > 0) return 1'b0;
    if (rho2 > r2 && wux * dx + wuy * dy > 0) return 1'b0;
    if (rho2 < r2 && wz > fl && wz < ce) return 1'b1;
    for (int k = 0; k < 2; k++) begin
      n = (k == 0 ? ce : fl) - wz;
      if (wuz != 0 && n != 0 && ((n > 0) == (wuz > 0))) begin
        px = dx * wuz + n * wux;
        py = dy * wuz + n * wuy;
        if (px * px + py * py < r2 * wuz * wuz) return 1'b1;
      end
    end
    a = wux * wux + wuy * wuy;
    b = dx * wux + dy * wuy;
    c = rho2 - r2;
    d = b * b - a * c;
    if (a == 0 || d <= 0) return 1'b0;
    s = isqrt(d);
    for (int k = 0; k < 2; k++) begin
      u = (k == 0) ? -b - s : -b + s;
      t = wuz * u;
      if (u > 0 && (fl - wz) * a < t && t < (ce - wz) * a) return 1'b1;
    end
    return 1'b0;
  endfunction

  assign decisions_pending = keep_queue.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      cyl_x <= '0;
      cyl_y <= '0;
      cyl_radius <= '0;
      cyl_floor <= '0;
      cyl_ceiling <= '0;
      fail_count <= 0;
      keep_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_AXIS_X:    cyl_x <= cfg_data;
          CFG_AXIS_Y:    cyl_y <= cfg_data;
          CFG_RADIUS:    cyl_radius <= cfg_data[22:0];
          CFG_FLOOR_Z:   cyl_floor <= cfg_data;
          CFG_CEILING_Z: cyl_ceiling <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        keep_queue.push_back(predict_keep(in_already_dead, in_particle_kind,
                                          in_energy_kev, in_pos_x, in_pos_y, in_pos_z,
                                          in_dir_x, in_dir_y, in_dir_z));
      if (out_valid && out_ready) begin
        if (keep_queue.size() == 0) begin
          $error("keep: unexpected transfer, value %0b", out_keep);
          fail_count <= fail_count + 1;
        end else if (keep_queue[0] !== out_keep) begin
          $error("keep: expected %0b, actual %0b", keep_queue[0], out_keep);
          fail_count <= fail_count + 1;
          void'(keep_queue.pop_front());
        end else begin
          void'(keep_queue.pop_front());
        end
      end
    end
  end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the track cylinder crossing filter: directed tracks on every
// decision path, then random tracks over several cylinder settings with
// random gaps and stalls on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import tccf_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_already_dead = 1'b0;
  logic [2:0]  in_particle_kind = '0;
  logic [19:0] in_energy_kev = '0;
  logic [23:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic [15:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_keep;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;
  int          fail_count;
  int          decisions_pending;

  bit          calm;
  bit          long_hold;
  int          span;
  int          cx, cy, cf, cc;

  always #2 clk = ~clk;

  track_cylinder_crossing_filter_core u_dut (.*);

  tccf_checker u_chk (.*);

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [23:0] data);
    bit ok;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do begin
      @(negedge clk) ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
  endtask

  task automatic set_cylinder(int ax, int ay, int r, int fl, int ce);
    repeat (60) @(posedge clk);
    cx = ax; cy = ay; cf = fl; cc = ce;
    span = (r < 16) ? 4000 : r;
    write_reg(CFG_AXIS_X, ax[23:0]);
    write_reg(CFG_AXIS_Y, ay[23:0]);
    write_reg(CFG_RADIUS, r[23:0]);
    write_reg(CFG_FLOOR_Z, fl[23:0]);
    write_reg(CFG_CEILING_Z, ce[23:0]);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_track(bit dead, logic [2:0] kind, logic [19:0] e, int x, int y,
                            int z, int ux, int uy, int uz);
    bit ok;
    int g;
    in_valid <= 1'b1;
    in_already_dead <= dead;
    in_particle_kind <= kind;
    in_energy_kev <= e;
    in_pos_x <= x[23:0];
    in_pos_y <= y[23:0];
    in_pos_z <= z[23:0];
    in_dir_x <= ux[15:0];
    in_dir_y <= uy[15:0];
    in_dir_z <= uz[15:0];
    do begin
      @(negedge clk) ok = in_ready;
      @(posedge clk);
    end while (!ok);
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (decisions_pending != 0) @(posedge clk);
  endtask

  function automatic int near(int c, int s);
    return c + $signed($urandom_range(0, 4 * s)) - 2 * s;
  endfunction

  task automatic random_track();
    int r, kind, ux, uy, uz;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      send_track(1'($urandom), 3'($urandom_range(0, 7)), 20'($urandom), $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      kind = (r < 70) ? KIND_MUON : $urandom_range(0, 7);
      ux = $signed($urandom_range(0, 65535)) - 32768;
      uy = $signed($urandom_range(0, 65535)) - 32768;
      uz = $signed($urandom_range(0, 65535)) - 32768;
      case ($urandom_range(0, 5))
        0: begin ux = 0; uy = 0; end
        1: uz = 0;
        2: begin ux = ux / 2; uy = uy / 2; end
        default: ;
      endcase
      send_track($urandom_range(0, 15) == 0, 3'(kind),
                 20'($urandom_range(0, 1) ? $urandom_range(200, 280) : $urandom),
                 near(cx, span), near(cy, span),
                 near((cf / 2) + (cc / 2), span), ux, uy, uz);
    end
  endtask

  always begin
    @(posedge clk);
    if (long_hold) begin
      long_hold = 1'b0;
      out_ready <= 1'b0;
      repeat (300) @(posedge clk);
    end else if (calm || $urandom_range(0, 99) < 60) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      repeat ($urandom_range(0, 99) < 90 ? $urandom_range(0, 3) : $urandom_range(5, 30))
        @(posedge clk);
    end
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_cylinder(100, -200, 1000, -2000, 2000);
    send_track(1, KIND_OPTICAL, 0, 100, -200, 0, 0, 0, 32767);
    send_track(0, KIND_OPTICAL, 0, 8388607, 8388607, 8388607, 0, 0, 0);
    send_track(0, KIND_ELECTRON, 239, 100, -200, 0, 0, 0, 0);
    send_track(0, KIND_ELECTRON, 240, 100, -200, 0, 0, 0, 0);
    send_track(0, KIND_GAMMA, 0, 100, -200, 0, 0, 0, 0);
    send_track(0, KIND_GAMMA, 1048575, 5000, -200, 0, 0, 0, 0);
    send_track(0, KIND_MASSLESS, 1048575, 100, -200, 0, 0, 0, 0);
    send_track(0, 3'd5, 0, 1100, -200, 2000, 0, 0, 0);
    send_track(0, 3'd6, 0, 100, -200, 2001, 0, 0, 0);
    send_track(0, 3'd7, 0, -8388608, -8388608, -8388608, 0, 0, 0);
    send_track(0, KIND_MUON, 0, 100, -200, 0, 32767, 0, 0);
    send_track(0, KIND_MUON, 0, 100, -200, 5000, 0, 0, 32767);
    send_track(0, KIND_MUON, 0, 100, -200, 5000, 0, 0, -32768);
    send_track(0, KIND_MUON, 0, 100, -200, -5000, 0, 0, -32768);
    send_track(0, KIND_MUON, 0, 100, -200, -5000, 0, 0, 32767);
    send_track(0, KIND_MUON, 0, 3100, -200, 0, 32767, 0, 0);
    send_track(0, KIND_MUON, 0, 3100, -200, 0, -32768, 0, 0);
    send_track(0, KIND_MUON, 0, 3100, -200, 0, -23170, 0, 23170);
    send_track(0, KIND_MUON, 0, 3100, 5000, 0, -32768, -32768, 0);
    send_track(0, KIND_MUON, 0, 100, -200, 2000, 0, 0, 0);
    send_track(0, KIND_MUON, 0, 8388607, 8388607, 8388607, -32768, -32768, -32768);
    send_track(0, KIND_MUON, 0, -8388608, -8388608, -8388608, 32767, 32767, 32767);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_cylinder(-8388608, 8388607, 8388607, -8388608, 8388607);
        1: set_cylinder(3000, 4000, 0, -100, 100);
        2: set_cylinder(-50, 70, 500, 600, -600);
        3: set_cylinder(8388607, -8388608, 1, 8388607, -8388608);
        4: set_cylinder($signed($urandom_range(0, 200000)) - 100000,
                        $signed($urandom_range(0, 200000)) - 100000,
                        $urandom_range(10, 50000), -30000, 30000);
        default: set_cylinder(0, 0, 2000, -5000, 5000);
      endcase
      if (ph == 1) long_hold = 1'b1;
      for (int i = 0; i < 270; i++) begin
        if (i % 90 == 0) calm = $urandom_range(0, 3) == 0;
        random_track();
      end
      calm = 1'b0;
      drain();
    end
    repeat (60) @(posedge clk);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> sim.f
design/tccf_pkg.sv
design/track_cylinder_crossing_filter_core.sv
tb/tccf_checker.sv
tb/tb_top.sv
